[hw/rtl/iterative_white_balance_gain_defines.svh]
// Assertion macros shared by the white balance gain RTL.
`ifndef ITERATIVE_WHITE_BALANCE_GAIN_DEFINES_SVH
`define ITERATIVE_WHITE_BALANCE_GAIN_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define IWB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define IWB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/iwb_pkg.sv]
// Types and constants of the white balance gain block.
`default_nettype none
package iwb_pkg;

    localparam int PixW    = 8;
    localparam int GainW   = 10;
    localparam int SumW    = 32;
    localparam int CfgIdxW = 8;

    localparam logic [GainW-1:0] GainOne = 10'd256;
    localparam logic [GainW-1:0] GainMax = 10'd1023;

    // register indexes of the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_WHITE_THRESHOLD = 8'd0,
        CFG_GAIN_STEP       = 8'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] white_threshold;
        logic [7:0] gain_step;
    } cfg_t;

    typedef struct packed {
        logic [PixW-1:0]   pix_b;
        logic [PixW-1:0]   pix_g;
        logic [PixW-1:0]   pix_r;
        logic [7:0]        stat_y;
        logic signed [7:0] stat_cb;
        logic signed [7:0] stat_cr;
        logic              frame_last;
    } pix_in_t;

    typedef struct packed {
        logic [PixW-1:0]  out_b;
        logic [PixW-1:0]  out_g;
        logic [PixW-1:0]  out_r;
        logic [GainW-1:0] blue_gain_now;
        logic [GainW-1:0] red_gain_now;
        logic             gains_updated;
    } pix_out_t;

    // classified item: chroma deltas are zero for pixels that are not near white
    typedef struct packed {
        logic [PixW-1:0] pix_b;
        logic [PixW-1:0] pix_g;
        logic [PixW-1:0] pix_r;
        logic [7:0]      cb_delta;
        logic [7:0]      cr_delta;
        logic            frame_last;
    } qent_t;

endpackage
`default_nettype wire

[hw/rtl/iwb_pix_in_if.sv]
// Input pixel stream channel.
`default_nettype none
interface iwb_pix_in_if;
    import iwb_pkg::*;

    logic    valid;
    logic    ready;
    pix_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/iwb_pix_out_if.sv]
// Output pixel stream channel.
`default_nettype none
interface iwb_pix_out_if;
    import iwb_pkg::*;

    logic     valid;
    logic     ready;
    pix_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/iwb_cfg_if.sv]
// Configuration write channel.
`default_nettype none
interface iwb_cfg_if;
    import iwb_pkg::*;

    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [7:0]         wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

[hw/rtl/iterative_white_balance_gain.sv]
// Top level of the iterative white balance gain block.
`default_nettype none
// Scales blue and red of each pixel by per-frame gains in Q2.8 and adapts the gains
// once per frame from signed Cb/Cr sums of near-white statistics pixels. One pixel
// beat is taken per clock while the queue has room, and one result beat leaves per clock
// when the sink is ready; a result goes from the queue, written at the edge that accepts
// its pixel, through the accumulate stage register to the output register.
// The pixel following a frame end is scaled with the updated gain. The front end
// classifies pixels and writes a QUEUE_DEPTH entry queue; with the accumulate stage
// and the output register the block holds up to QUEUE_DEPTH + 2 beats, so input keeps
// flowing while the output stalls until that many are inside.
// Gains reset to 1.0, sums to zero; no clearing pass is needed after reset.
// Configuration is always ready and should be written while the block is idle.
module iterative_white_balance_gain #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    iwb_pix_in_if.sink     pix_in,
    iwb_pix_out_if.source  pix_out,
    iwb_cfg_if.sink        cfg
);
    import iwb_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    qent_t q_wdata;
    qent_t q_rdata;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_WHITE_THRESHOLD: cfg_next.white_threshold = cfg.wdata;
                CFG_GAIN_STEP:       cfg_next.gain_step       = cfg.wdata;
                default:             cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.white_threshold <= 8'd180;
            cfg_reg.gain_step       <= 8'd13;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    iwb_front u_front (
        .in_valid (pix_in.valid),
        .in_ready (pix_in.ready),
        .in_data  (pix_in.data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    iwb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    iwb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_data  (pix_out.data)
    );

endmodule
`default_nettype wire

[hw/rtl/iwb_front.sv]
// Front end: accepts pixel beats and classifies them as near white or not.
`default_nettype none
module iwb_front (
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  iwb_pkg::pix_in_t     in_data,
    input  iwb_pkg::cfg_t        cfg,
    input  wire logic            q_full,
    output logic                 q_push,
    output iwb_pkg::qent_t       q_data
);
    import iwb_pkg::*;

    logic [7:0]        cb_mag;
    logic [7:0]        cr_mag;
    logic signed [9:0] white_metric;
    logic signed [9:0] thr_ext;
    logic              is_white;

    // handshake: take a beat whenever the queue has room
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // chroma magnitudes; -128 maps to 128, which fits unsigned 8 bits
    assign cb_mag = in_data.stat_cb[7] ? (~in_data.stat_cb + 8'd1) : in_data.stat_cb;
    assign cr_mag = in_data.stat_cr[7] ? (~in_data.stat_cr + 8'd1) : in_data.stat_cr;

    // Y - |Cb| - |Cr| spans [-256, 255], signed compare against threshold
    assign white_metric = $signed({2'b00, in_data.stat_y}) - $signed({2'b00, cb_mag})
                          - $signed({2'b00, cr_mag});
    assign thr_ext      = $signed({2'b00, cfg.white_threshold});
    assign is_white     = white_metric > thr_ext;

    // classified entry
    always_comb
    begin
        q_data.pix_b      = in_data.pix_b;
        q_data.pix_g      = in_data.pix_g;
        q_data.pix_r      = in_data.pix_r;
        q_data.cb_delta   = is_white ? in_data.stat_cb : 8'd0;
        q_data.cr_delta   = is_white ? in_data.stat_cr : 8'd0;
        q_data.frame_last = in_data.frame_last;
    end

endmodule
`default_nettype wire

[hw/rtl/iwb_queue.sv]
// Short flip-flop queue between front and back end.
`default_nettype none
`include "iterative_white_balance_gain_defines.svh"
module iwb_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  iwb_pkg::qent_t   push_data,
    output logic             full,
    input  wire logic        pop,
    output iwb_pkg::qent_t   pop_data,
    output logic             empty
);
    import iwb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    qent_t           mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `IWB_ASSERT_IMP(a_q_no_overflow, push, !full, "queue push while full")
    `IWB_ASSERT_IMP(a_q_no_underflow, pop, !empty, "queue pop while empty")
    `IWB_ASSERT_NEXT(a_q_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "queue count did not rise on push")

endmodule
`default_nettype wire

[hw/rtl/iwb_back.sv]
// Back end: chroma accumulation, end-of-frame gain update, pixel scaling.
`default_nettype none
`include "iterative_white_balance_gain_defines.svh"
module iwb_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  iwb_pkg::cfg_t      cfg,
    input  wire logic          q_empty,
    input  iwb_pkg::qent_t     q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output iwb_pkg::pix_out_t  out_data
);
    import iwb_pkg::*;

    // saturating add of a signed chroma value to a signed sum
    function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] acc,
                                                input logic [7:0] d);
        logic [SumW:0] s;
        begin
            s = {acc[SumW-1], acc} + {{(SumW + 1 - 8){d[7]}}, d};
            if (s[SumW] != s[SumW-1])
            begin
                sat_add = s[SumW] ? {1'b1, {(SumW - 1){1'b0}}} : {1'b0, {(SumW - 1){1'b1}}};
            end
            else
            begin
                sat_add = s[SumW-1:0];
            end
        end
    endfunction

    // magnitude of a signed sum, one bit wider so the most negative value fits
    function automatic logic [SumW:0] sum_mag(input logic [SumW-1:0] x);
        begin
            sum_mag = x[SumW-1] ? (~{1'b1, x} + 1'b1) : {1'b0, x};
        end
    endfunction

    // gain step against the sum sign, clamped to [0, GainMax]
    function automatic logic [GainW-1:0] step_gain(input logic [GainW-1:0] g,
                                                   input logic down,
                                                   input logic [7:0] st);
        logic [GainW:0] up_sum;
        begin
            up_sum = {1'b0, g} + {{(GainW + 1 - 8){1'b0}}, st};
            if (down)
            begin
                step_gain = (g > {{(GainW - 8){1'b0}}, st}) ?
                            g - {{(GainW - 8){1'b0}}, st} : '0;
            end
            else
            begin
                step_gain = (up_sum > {1'b0, GainMax}) ? GainMax : up_sum[GainW-1:0];
            end
        end
    endfunction

    // scale, round half up, clamp to 255
    function automatic logic [PixW-1:0] scale_px(input logic [PixW-1:0] px,
                                                 input logic [GainW-1:0] g);
        logic [PixW+GainW-1:0] rnd;
        begin
            rnd = px * g + (PixW + GainW)'(128);
            scale_px = (|rnd[PixW+GainW-1:16]) ? {PixW{1'b1}} : rnd[15:8];
        end
    endfunction

    logic [SumW-1:0]  cb_sum_reg;
    logic [SumW-1:0]  cb_sum_next;
    logic [SumW-1:0]  cr_sum_reg;
    logic [SumW-1:0]  cr_sum_next;
    logic [SumW-1:0]  cb_fin;
    logic [SumW-1:0]  cr_fin;

    logic             a_valid_reg;
    logic             a_valid_next;
    logic [PixW-1:0]  a_pix_b_reg;
    logic [PixW-1:0]  a_pix_g_reg;
    logic [PixW-1:0]  a_pix_r_reg;
    logic             a_last_reg;
    logic [SumW-1:0]  a_cb_reg;
    logic [SumW-1:0]  a_cr_reg;

    logic [GainW-1:0] blue_gain_reg;
    logic [GainW-1:0] blue_gain_next;
    logic [GainW-1:0] red_gain_reg;
    logic [GainW-1:0] red_gain_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    pix_out_t         out_data_reg;
    pix_out_t         out_data_next;

    logic             advance;
    logic             b_move;
    logic             a_load;
    logic             pick_blue;
    logic             cb_pos;
    logic             cr_pos;

    // pipeline control: output register frees when empty or taken
    assign advance = !out_valid_reg || out_ready;
    assign b_move  = a_valid_reg && advance;
    assign a_load  = !q_empty && (!a_valid_reg || b_move);
    assign q_pop   = a_load;

    // stage A: accumulate near-white chroma; frame end clears the running sums
    assign cb_fin = sat_add(cb_sum_reg, q_data.cb_delta);
    assign cr_fin = sat_add(cr_sum_reg, q_data.cr_delta);

    always_comb
    begin
        cb_sum_next  = cb_sum_reg;
        cr_sum_next  = cr_sum_reg;
        a_valid_next = a_valid_reg;
        if (a_load)
        begin
            cb_sum_next  = q_data.frame_last ? '0 : cb_fin;
            cr_sum_next  = q_data.frame_last ? '0 : cr_fin;
            a_valid_next = 1'b1;
        end
        else if (b_move)
        begin
            a_valid_next = 1'b0;
        end
    end

    // stage B: gain decision from the closing sums
    assign pick_blue = sum_mag(a_cb_reg) > sum_mag(a_cr_reg);
    assign cb_pos    = !a_cb_reg[SumW-1] && (a_cb_reg != '0);
    assign cr_pos    = !a_cr_reg[SumW-1] && (a_cr_reg != '0);

    always_comb
    begin
        blue_gain_next = blue_gain_reg;
        red_gain_next  = red_gain_reg;
        if (b_move && a_last_reg)
        begin
            if (pick_blue)
            begin
                blue_gain_next = step_gain(blue_gain_reg, cb_pos, cfg.gain_step);
            end
            else
            begin
                red_gain_next = step_gain(red_gain_reg, cr_pos, cfg.gain_step);
            end
        end
    end

    // stage B: scaling with the gains held before this beat's update
    always_comb
    begin
        out_data_next.out_b         = scale_px(a_pix_b_reg, blue_gain_reg);
        out_data_next.out_g         = a_pix_g_reg;
        out_data_next.out_r         = scale_px(a_pix_r_reg, red_gain_reg);
        out_data_next.blue_gain_now = blue_gain_next;
        out_data_next.red_gain_now  = red_gain_next;
        out_data_next.gains_updated = a_last_reg;
        out_valid_next              = b_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cb_sum_reg    <= '0;
            cr_sum_reg    <= '0;
            a_valid_reg   <= 1'b0;
            blue_gain_reg <= GainOne;
            red_gain_reg  <= GainOne;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cb_sum_reg    <= cb_sum_next;
            cr_sum_reg    <= cr_sum_next;
            a_valid_reg   <= a_valid_next;
            blue_gain_reg <= blue_gain_next;
            red_gain_reg  <= red_gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_pix_b_reg <= q_data.pix_b;
            a_pix_g_reg <= q_data.pix_g;
            a_pix_r_reg <= q_data.pix_r;
            a_last_reg  <= q_data.frame_last;
            a_cb_reg    <= cb_fin;
            a_cr_reg    <= cr_fin;
        end
        if (b_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `IWB_ASSERT_NEXT(a_gain_only_at_frame_end, !(b_move && a_last_reg),
        blue_gain_reg == $past(blue_gain_reg) && red_gain_reg == $past(red_gain_reg),
        "gain changed outside a frame end")
    `IWB_ASSERT_NEXT(a_sums_clear_at_frame_end, a_load && q_data.frame_last,
        cb_sum_reg == '0 && cr_sum_reg == '0, "chroma sums not cleared at frame end")
    `IWB_ASSERT_IMP(a_no_load_into_stalled_stage, a_valid_reg && !advance, !a_load,
        "stage A overwritten while stalled")

endmodule
`default_nettype wire

[dv/iwb_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the white balance gain block: models gains and chroma sums, checks each result beat.
module iwb_checker (
    input  logic   clk,
    input  logic   rst_n,
    iwb_pix_in_if  pin,
    iwb_pix_out_if pout,
    iwb_cfg_if     cfg,
    output int     errors,
    output int     pending
);
    import iwb_pkg::*;

    localparam longint SumHi = 64'sd2147483647;
    localparam longint SumLo = -SumHi - 64'sd1;

    // shadow of the configuration and the adaptive state
    logic [7:0]       white_thr;
    logic [7:0]       gain_inc;
    logic [GainW-1:0] bgain;
    logic [GainW-1:0] rgain;
    longint           cb_acc;
    longint           cr_acc;

    // balanced pixels still to come out of the block, oldest first
    pix_out_t         balanced_pix_q[$];
    int               err_cnt;

    // Q2.8 scale, round half up, clamp to 255
    function automatic logic [7:0] scale_chan(input logic [7:0] px, input logic [GainW-1:0] g);
        int p;
        p = (int'(px) * int'(g) + 128) >>> 8;
        return (p > 255) ? 8'd255 : p[7:0];
    endfunction

    // one gain step, saturating to the Q2.8 range
    function automatic logic [GainW-1:0] step_gain_toward(input logic [GainW-1:0] g,
                                                          input bit down,
                                                          input logic [7:0] st);
        int s;
        if (down)
            s = int'(g) - int'(st);
        else
            s = int'(g) + int'(st);
        if (s < 0)
            s = 0;
        if (s > int'(GainMax))
            s = int'(GainMax);
        return s[GainW-1:0];
    endfunction

    // chroma sums stick at the 32 bit signed limits
    function automatic longint add_sat32(input longint acc, input longint d);
        longint s;
        s = acc + d;
        if (s > SumHi)
            return SumHi;
        if (s < SumLo)
            return SumLo;
        return s;
    endfunction

    // expected result of one pixel beat; updates the shadow state
    function automatic pix_out_t balance_pixel(input pix_in_t p);
        pix_out_t r;
        int       y;
        int       cb;
        int       cr;
        longint   cb_mag;
        longint   cr_mag;
        r.out_b = scale_chan(p.pix_b, bgain);
        r.out_g = p.pix_g;
        r.out_r = scale_chan(p.pix_r, rgain);
        y  = int'(p.stat_y);
        cb = int'($signed(p.stat_cb));
        cr = int'($signed(p.stat_cr));
        // near-white test is signed
        if (y - (cb < 0 ? -cb : cb) - (cr < 0 ? -cr : cr) > int'(white_thr))
        begin
            cb_acc = add_sat32(cb_acc, longint'(cb));
            cr_acc = add_sat32(cr_acc, longint'(cr));
        end
        // frame end: the larger sum magnitude picks the gain, ties go to red
        if (p.frame_last)
        begin
            cb_mag = (cb_acc < 0) ? -cb_acc : cb_acc;
            cr_mag = (cr_acc < 0) ? -cr_acc : cr_acc;
            if (cb_mag > cr_mag)
                bgain = step_gain_toward(bgain, cb_acc > 0, gain_inc);
            else
                rgain = step_gain_toward(rgain, cr_acc > 0, gain_inc);
            cb_acc = 0;
            cr_acc = 0;
        end
        r.blue_gain_now = bgain;
        r.red_gain_now  = rgain;
        r.gains_updated = p.frame_last;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            err_cnt++;
        end
    endtask

    // watch all three channels; state changes only on accepted beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        pix_out_t want;
        pix_out_t got;
        if (!rst_n)
        begin
            white_thr = 8'd180;
            gain_inc  = 8'd13;
            bgain     = GainOne;
            rgain     = GainOne;
            cb_acc    = 0;
            cr_acc    = 0;
            balanced_pix_q.delete();
            err_cnt   = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_WHITE_THRESHOLD: white_thr = cfg.wdata;
                    CFG_GAIN_STEP:       gain_inc  = cfg.wdata;
                    default: ;
                endcase
            end
            if (pin.valid && pin.ready)
                balanced_pix_q.push_back(balance_pixel(pin.data));
            if (pout.valid && pout.ready)
            begin
                got = pout.data;
                if (balanced_pix_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %h",
                             $time, got);
                    err_cnt++;
                end
                else
                begin
                    want = balanced_pix_q.pop_front();
                    check_field("out_b", int'(want.out_b), int'(got.out_b));
                    check_field("out_g", int'(want.out_g), int'(got.out_g));
                    check_field("out_r", int'(want.out_r), int'(got.out_r));
                    check_field("blue_gain_now", int'(want.blue_gain_now),
                                int'(got.blue_gain_now));
                    check_field("red_gain_now", int'(want.red_gain_now),
                                int'(got.red_gain_now));
                    check_field("gains_updated", int'(want.gains_updated),
                                int'(got.gains_updated));
                end
            end
            errors  <= err_cnt;
            pending <= balanced_pix_q.size();
        end
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the white balance gain block: clock, reset, stimulus and verdict.
module tb_top;
    import iwb_pkg::*;

    localparam int DrainCycles = 8;
    localparam int DrainGuard  = 20000;
    localparam int RandPhases  = 8;
    localparam int PhaseItems  = 66;

    typedef enum {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_SPARSE,
        RDY_PATTERN
    } stall_mode_t;

    logic clk;
    logic rst_n;

    iwb_pix_in_if  pin ();
    iwb_pix_out_if pout ();
    iwb_cfg_if     cfg ();

    int errors;
    int pending;
    int n_pix;
    int n_frames;
    int n_phases;
    int burst_left;

    iterative_white_balance_gain DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pin),
        .pix_out (pout),
        .cfg     (cfg)
    );

    iwb_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .pin     (pin),
        .pout    (pout),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #5_000_000;
        $display("%0t: run timed out", $time);
        $display("iterative_white_balance_gain verification failed");
        $finish;
    end

    // output side back-pressure; the mode is redrawn at random from four after a random span
    initial
    begin : out_stall
        stall_mode_t mode;
        int          mode_left;
        logic [7:0]  pat;
        pout.ready <= 1'b0;
        mode      = RDY_ALWAYS;
        mode_left = 0;
        pat       = 8'h01;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 96);
                pat       = 8'($urandom_range(1, 255));
            end
            mode_left--;
            case (mode)
                RDY_ALWAYS: pout.ready <= 1'b1;
                RDY_HALF:   pout.ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: pout.ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    pout.ready <= pat[0];
                    pat = {pat[6:0], pat[7]};
                end
            endcase
        end
    end

    function automatic pix_in_t mk_pix(input int b, input int g, input int r, input int y,
                                       input int cb, input int cr, input bit last);
        pix_in_t p;
        p.pix_b      = b[7:0];
        p.pix_g      = g[7:0];
        p.pix_r      = r[7:0];
        p.stat_y     = y[7:0];
        p.stat_cb    = cb[7:0];
        p.stat_cr    = cr[7:0];
        p.frame_last = last;
        return p;
    endfunction

    // mostly near-white statistics so the sums move; the rest fully random
    function automatic pix_in_t rand_pix(input bit last);
        pix_in_t p;
        int      cb;
        int      cr;
        p.pix_b = 8'($urandom_range(0, 255));
        p.pix_g = 8'($urandom_range(0, 255));
        p.pix_r = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) != 0)
        begin
            cb = int'($urandom_range(0, 60)) - 30;
            cr = int'($urandom_range(0, 60)) - 30;
            p.stat_y  = 8'($urandom_range(140, 255));
            p.stat_cb = cb[7:0];
            p.stat_cr = cr[7:0];
        end
        else
        begin
            p.stat_y  = 8'($urandom_range(0, 255));
            p.stat_cb = 8'($urandom_range(0, 255));
            p.stat_cr = 8'($urandom_range(0, 255));
        end
        p.frame_last = last;
        return p;
    endfunction

    // one pixel beat, then maybe a gap when the burst runs out
    task automatic push_pix(input pix_in_t p);
        pin.valid <= 1'b1;
        pin.data  <= p;
        @(posedge clk);
        while (!pin.ready)
            @(posedge clk);
        n_pix++;
        if (p.frame_last)
            n_frames++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                pin.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // both registers back to back; only called with the block idle
    task automatic write_config(input logic [7:0] thr, input logic [7:0] stp);
        cfg.valid <= 1'b1;
        cfg.index <= CFG_WHITE_THRESHOLD;
        cfg.wdata <= thr;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.index <= CFG_GAIN_STEP;
        cfg.wdata <= stp;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        n_phases++;
    endtask

    // stop sending, wait for every expected result, then let the block idle
    task automatic drain();
        int guard;
        guard = 0;
        pin.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && guard < DrainGuard)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DrainCycles) @(posedge clk);
    endtask

    // random frames, mostly short, now and then longer
    task automatic run_frames(input int n_items);
        int left;
        int len;
        int k;
        left = n_items;
        while (left > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(13, 48);
            else
                len = $urandom_range(1, 12);
            for (k = 0; k < len; k++)
                push_pix(rand_pix(k == len - 1));
            left -= len;
        end
    endtask

    // stimulus
    initial
    begin : stim
        int ph;
        rst_n      <= 1'b0;
        pin.valid  <= 1'b0;
        pin.data   <= '0;
        cfg.valid  <= 1'b0;
        cfg.index  <= CFG_WHITE_THRESHOLD;
        cfg.wdata  <= 8'd0;
        n_pix      = 0;
        n_frames   = 0;
        n_phases   = 1;
        burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: field extremes, threshold boundary, each way a gain can move
        push_pix(mk_pix(0, 0, 0, 0, 0, 0, 0));
        push_pix(mk_pix(255, 255, 255, 255, 0, 0, 0));
        push_pix(mk_pix(128, 1, 127, 255, -128, 127, 0));
        push_pix(mk_pix(1, 128, 2, 0, -128, -128, 0));
        push_pix(mk_pix(200, 100, 50, 190, 5, 5, 0));     // margin equals threshold
        push_pix(mk_pix(3, 4, 5, 191, 5, 5, 0));          // one above threshold
        push_pix(mk_pix(10, 20, 30, 200, 10, -2, 1));     // blue steps down
        push_pix(mk_pix(255, 0, 255, 0, 0, 0, 1));        // no white: red up
        push_pix(mk_pix(17, 18, 19, 250, -20, 20, 1));    // tie goes to red, down
        push_pix(mk_pix(99, 99, 99, 250, 3, -30, 1));     // red up
        push_pix(mk_pix(77, 66, 55, 250, -40, 2, 1));     // blue up
        push_pix(mk_pix(129, 127, 131, 255, 127, -1, 0));
        drain();

        // largest step, zero threshold: run both gains into their limits
        write_config(8'd0, 8'd255);
        push_pix(mk_pix(255, 0, 255, 0, 0, 0, 1));
        push_pix(mk_pix(255, 0, 255, 0, 0, 0, 1));
        push_pix(mk_pix(255, 0, 255, 0, 0, 0, 1));        // red saturates high
        push_pix(mk_pix(255, 255, 255, 1, 0, 0, 1));
        push_pix(mk_pix(200, 200, 200, 255, 100, 0, 1));
        push_pix(mk_pix(200, 200, 200, 255, 100, 0, 1));  // blue saturates at zero
        push_pix(mk_pix(255, 0, 128, 60, 0, 0, 0));
        push_pix(mk_pix(1, 2, 1, 0, 0, 0, 1));
        drain();

        // top threshold never counts a pixel
        write_config(8'd255, 8'd255);
        push_pix(mk_pix(255, 255, 255, 255, 0, 0, 1));
        push_pix(mk_pix(64, 32, 16, 255, 0, 0, 1));
        drain();

        // random phases, extremes of both registers first
        for (ph = 0; ph < RandPhases; ph++)
        begin
            case (ph)
                0:       write_config(8'd255, 8'd0);
                1:       write_config(8'd0, 8'd255);
                2:       write_config(8'd180, 8'd13);
                3:       write_config(8'd0, 8'd0);
                4:       write_config(8'd255, 8'd255);
                default: write_config(8'($urandom_range(100, 230)),
                                      8'($urandom_range(0, 255)));
            endcase
            run_frames(PhaseItems);
            drain();
        end

        $display("Sent %0d pixels in %0d frames across %0d register settings",
                 n_pix, n_frames, n_phases);
        $display("Settings spanned threshold and step 0 and 255; gains hit both limits");
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (errors == 0 && pending == 0)
            $display("iterative_white_balance_gain verification clean");
        else
            $display("iterative_white_balance_gain verification failed");
        $finish;
    end

endmodule

[iterative_white_balance_gain.f]
+incdir+hw/rtl
hw/rtl/iwb_pkg.sv
hw/rtl/iwb_pix_in_if.sv
hw/rtl/iwb_pix_out_if.sv
hw/rtl/iwb_cfg_if.sv
hw/rtl/iwb_front.sv
hw/rtl/iwb_queue.sv
hw/rtl/iwb_back.sv
hw/rtl/iterative_white_balance_gain.sv
dv/iwb_checker.sv
dv/tb_top.sv
